// File: sv/pli_pkg.sv
// ----------------------------------------------------------------------------
// pli_pkg
// Shared widths, operation codes and status codes of the positional list.
// ----------------------------------------------------------------------------
`default_nettype none

package pli_pkg;

  localparam int CAPACITY   = 128;
  localparam int ELEM_WIDTH = 32;

  // fixed field widths of the request and response
  localparam int MODE_W   = 2;
  localparam int POS_W    = 8;
  localparam int STATUS_W = 2;
  localparam int LEN_W    = 8;

  localparam int ADDR_W = $clog2(CAPACITY);
  localparam int CNT_W  = $clog2(CAPACITY + 1);
  localparam int CMP_W  = ((POS_W > CNT_W) ? POS_W : CNT_W) + 1;

  localparam logic [MODE_W-1:0] MODE_GET = 2'd0;
  localparam logic [MODE_W-1:0] MODE_INS = 2'd1;
  localparam logic [MODE_W-1:0] MODE_DEL = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
  localparam logic [STATUS_W-1:0] ST_BADPOS = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL   = 2'd2;

endpackage

`default_nettype wire

// File: sv/pli_if.sv
// ----------------------------------------------------------------------------
// pli_req_if / pli_rsp_if
// Valid/ready channels carrying list requests and their responses.
// ----------------------------------------------------------------------------
`default_nettype none

interface pli_req_if;
  import pli_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [MODE_W-1:0]     mode;
  logic [POS_W-1:0]      position;
  logic [ELEM_WIDTH-1:0] element_in;

  modport source (output valid, output mode, output position, output element_in,
                  input ready);
  modport sink   (input valid, input mode, input position, input element_in,
                  output ready);
endinterface

interface pli_rsp_if;
  import pli_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [STATUS_W-1:0]   status;
  logic [ELEM_WIDTH-1:0] element_out;
  logic [LEN_W-1:0]      list_length;

  modport source (output valid, output status, output element_out, output list_length,
                  input ready);
  modport sink   (input valid, input status, input element_out, input list_length,
                  output ready);
endinterface

`default_nettype wire

// File: sv/pli_ram.sv
// ----------------------------------------------------------------------------
// pli_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
`default_nettype none

module pli_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output      logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// File: sv/positional_list_insert_delete.sv
// One request is in flight at a time; the next is taken once the response is registered.
// Inserts and deletes move the tail through the RAM one entry per cycle.
// Reset (rst_n low, synchronous) empties the list and clears the handshake state; the
//   element RAM is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
// positional_list_insert_delete
// Ordered list in a RAM with get, insert-before and delete by 1-based position.
// ----------------------------------------------------------------------------
`default_nettype none

module positional_list_insert_delete (
  input wire logic  clk,
  input wire logic  rst_n,
  pli_req_if.sink   in_req,
  pli_rsp_if.source out_rsp
);
  import pli_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_GETW, S_INS, S_INSW, S_DELR, S_DEL, S_FIN
  } state_t;

  state_t                state_r;
  logic [CNT_W-1:0]      count_r;
  logic [ADDR_W-1:0]     pos_m1_r;
  logic [ADDR_W-1:0]     rd_k_r;
  logic [ELEM_WIDTH-1:0] word_r;
  logic [ELEM_WIDTH-1:0] elem_r;
  logic [STATUS_W-1:0]   status_r;
  logic                  out_valid_r;
  logic [STATUS_W-1:0]   out_status_r;
  logic [ELEM_WIDTH-1:0] out_elem_r;
  logic [LEN_W-1:0]      out_len_r;

  logic                  accept;
  logic [CMP_W-1:0]      pos_ext;
  logic [CMP_W-1:0]      cnt_ext;
  logic                  range_rd;
  logic                  range_ins;
  logic                  full;
  logic                  get_ok;
  logic                  ins_go;
  logic                  ins_app;
  logic                  ins_full;
  logic                  del_ok;
  logic [ADDR_W-1:0]     in_pos_m1;
  logic [ADDR_W-1:0]     last_addr;
  logic                  out_free;

  logic                  wr_en;
  logic [ADDR_W-1:0]     wr_addr;
  logic [ELEM_WIDTH-1:0] wr_data;
  logic                  rd_en;
  logic [ADDR_W-1:0]     rd_addr;
  logic [ELEM_WIDTH-1:0] rd_data;

  assign in_req.ready        = (state_r == S_IDLE);
  assign out_rsp.valid       = out_valid_r;
  assign out_rsp.status      = out_status_r;
  assign out_rsp.element_out = out_elem_r;
  assign out_rsp.list_length = out_len_r;

  assign accept    = in_req.valid && (state_r == S_IDLE);
  assign pos_ext   = CMP_W'(in_req.position);
  assign cnt_ext   = CMP_W'(count_r);
  assign range_rd  = (in_req.position != '0) && (pos_ext <= cnt_ext);
  assign range_ins = (in_req.position != '0) && (pos_ext <= cnt_ext + 1'b1);
  assign full      = (count_r == CNT_W'(CAPACITY));
  assign get_ok    = (in_req.mode == MODE_GET) && range_rd;
  assign del_ok    = (in_req.mode == MODE_DEL) && range_rd;
  assign ins_full  = (in_req.mode == MODE_INS) && range_ins && full;
  assign ins_go    = (in_req.mode == MODE_INS) && range_ins && !full;
  assign ins_app   = ins_go && (pos_ext == cnt_ext + 1'b1);
  assign in_pos_m1 = ADDR_W'(in_req.position - 1'b1);
  assign last_addr = ADDR_W'(count_r - 1'b1);
  assign out_free  = !out_valid_r || out_rsp.ready;

  // RAM port control
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = '0;
    wr_data = rd_data;
    rd_en   = 1'b0;
    rd_addr = '0;
    unique case (state_r)
      S_IDLE: begin
        if (accept && ins_app) begin
          wr_en   = 1'b1;
          wr_addr = ADDR_W'(count_r);
          wr_data = in_req.element_in;
        end else if (accept && ins_go) begin
          // start moving the tail up, last element first
          rd_en   = 1'b1;
          rd_addr = last_addr;
        end else if (accept && (get_ok || del_ok)) begin
          rd_en   = 1'b1;
          rd_addr = in_pos_m1;
        end
      end
      S_INS: begin
        wr_en   = 1'b1;
        wr_addr = ADDR_W'(rd_k_r + 1'b1);
        if (rd_k_r != pos_m1_r) begin
          rd_en   = 1'b1;
          rd_addr = ADDR_W'(rd_k_r - 1'b1);
        end
      end
      S_INSW: begin
        wr_en   = 1'b1;
        wr_addr = pos_m1_r;
        wr_data = word_r;
      end
      S_DELR: begin
        if (CNT_W'(pos_m1_r) + 1'b1 != count_r) begin
          rd_en   = 1'b1;
          rd_addr = ADDR_W'(pos_m1_r + 1'b1);
        end
      end
      S_DEL: begin
        wr_en   = 1'b1;
        wr_addr = ADDR_W'(rd_k_r - 1'b1);
        if (rd_k_r != last_addr) begin
          rd_en   = 1'b1;
          rd_addr = ADDR_W'(rd_k_r + 1'b1);
        end
      end
      S_GETW, S_FIN: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // a finishing request reloads the output register below
      if (out_valid_r && out_rsp.ready && (state_r != S_FIN)) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            pos_m1_r <= in_pos_m1;
            word_r   <= in_req.element_in;
            elem_r   <= '0;
            rd_k_r   <= last_addr;
            if (get_ok || ins_go || del_ok) begin
              status_r <= ST_OK;
            end else if (ins_full) begin
              status_r <= ST_FULL;
            end else begin
              status_r <= ST_BADPOS;
            end
            if (get_ok) begin
              state_r <= S_GETW;
            end else if (ins_app) begin
              count_r <= count_r + 1'b1;
              state_r <= S_FIN;
            end else if (ins_go) begin
              state_r <= S_INS;
            end else if (del_ok) begin
              state_r <= S_DELR;
            end else begin
              state_r <= S_FIN;
            end
          end
        end
        S_GETW: begin
          elem_r  <= rd_data;
          state_r <= S_FIN;
        end
        S_INS: begin
          if (rd_k_r == pos_m1_r) begin
            state_r <= S_INSW;
          end else begin
            rd_k_r <= ADDR_W'(rd_k_r - 1'b1);
          end
        end
        S_INSW: begin
          count_r <= count_r + 1'b1;
          state_r <= S_FIN;
        end
        S_DELR: begin
          elem_r <= rd_data;
          if (CNT_W'(pos_m1_r) + 1'b1 == count_r) begin
            // removing the last element: nothing to move
            count_r <= count_r - 1'b1;
            state_r <= S_FIN;
          end else begin
            rd_k_r  <= ADDR_W'(pos_m1_r + 1'b1);
            state_r <= S_DEL;
          end
        end
        S_DEL: begin
          if (rd_k_r == last_addr) begin
            count_r <= count_r - 1'b1;
            state_r <= S_FIN;
          end else begin
            rd_k_r <= ADDR_W'(rd_k_r + 1'b1);
          end
        end
        S_FIN: begin
          if (out_free) begin
            out_valid_r  <= 1'b1;
            out_status_r <= status_r;
            out_elem_r   <= elem_r;
            out_len_r    <= LEN_W'(count_r);
            state_r      <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  pli_ram #(
    .WIDTH (ELEM_WIDTH),
    .DEPTH (CAPACITY)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAPACITY))
    else $error("list count above capacity");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r != $past(count_r)) |->
      ((count_r == $past(count_r) + 1'b1) || (count_r + 1'b1 == $past(count_r))))
    else $error("list count changed by more than one");

  a_read_in_list: assert property (@(posedge clk) disable iff (!rst_n)
    rd_en |-> (CNT_W'(rd_addr) < count_r))
    else $error("read beyond the held elements");

  a_write_in_list: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> (CNT_W'(wr_addr) <= count_r))
    else $error("write beyond the end of the list");

  a_one_response: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIN && out_free) |=> (out_valid_r && state_r == S_IDLE))
    else $error("finished request did not produce a response");
`endif

endmodule

`default_nettype wire

// File: bench/pli_list_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pli_list_checker
// Watches the request and response channels of the positional list, keeps a
// shadow copy of the list to predict each response, and compares in order.
// ----------------------------------------------------------------------------

module pli_list_checker
  import pli_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  pli_req_if   req,
  pli_rsp_if   rsp,
  output int   error_count,
  output int   outstanding
);

  typedef struct {
    logic [STATUS_W-1:0]   status;
    logic [ELEM_WIDTH-1:0] element;
    logic [LEN_W-1:0]      length;
  } list_result_t;

  list_result_t          expected_q[$];
  logic [ELEM_WIDTH-1:0] shadow_list [CAPACITY];
  int                    shadow_len;
  int                    errors;

  // applies one request to the shadow list and returns the response it gives
  function automatic list_result_t apply_request(input logic [MODE_W-1:0] op,
                                                 input logic [POS_W-1:0] pos_bits,
                                                 input logic [ELEM_WIDTH-1:0] word);
    list_result_t r;
    int p;
    p = int'(pos_bits);
    r.status  = ST_BADPOS;
    r.element = '0;
    case (op)
      MODE_GET: begin
        if (p >= 1 && p <= shadow_len) begin
          r.element = shadow_list[p-1];
          r.status  = ST_OK;
        end
      end
      MODE_INS: begin
        // range is checked before fullness
        if (p >= 1 && p <= shadow_len + 1) begin
          if (shadow_len >= CAPACITY) begin
            r.status = ST_FULL;
          end else begin
            for (int k = shadow_len; k >= p; k--) shadow_list[k] = shadow_list[k-1];
            shadow_list[p-1] = word;
            shadow_len++;
            r.status = ST_OK;
          end
        end
      end
      MODE_DEL: begin
        if (p >= 1 && p <= shadow_len) begin
          r.element = shadow_list[p-1];
          for (int k = p; k < shadow_len; k++) shadow_list[k-1] = shadow_list[k];
          shadow_len--;
          r.status = ST_OK;
        end
      end
      default: ;
    endcase
    r.length = shadow_len[LEN_W-1:0];
    return r;
  endfunction

  function automatic void check_field(input string field, input logic [ELEM_WIDTH-1:0] want,
                                      input logic [ELEM_WIDTH-1:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
      errors++;
    end
  endfunction

  always @(posedge clk) begin
    list_result_t want;
    if (!rst_n) begin
      shadow_len = 0;
      expected_q.delete();
    end else begin
      if (rsp.valid && rsp.ready) begin
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected response, expected none, actual status %0d element %h length %0d",
                   $time, rsp.status, rsp.element_out, rsp.list_length);
          errors++;
        end else begin
          want = expected_q.pop_front();
          check_field("status", ELEM_WIDTH'(want.status), ELEM_WIDTH'(rsp.status));
          check_field("element_out", want.element, rsp.element_out);
          check_field("list_length", ELEM_WIDTH'(want.length), ELEM_WIDTH'(rsp.list_length));
        end
      end
      if (req.valid && req.ready)
        expected_q.push_back(apply_request(req.mode, req.position, req.element_in));
    end
    error_count <= errors;
    outstanding <= expected_q.size();
  end

endmodule

// File: bench/positional_list_insert_delete_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// positional_list_insert_delete_test
// Drives get, insert and delete requests into the positional list: a directed
// sweep of the edge cases, then rounds that fill the list to capacity, drain
// it, or mix operations, with random gaps on both channels.
// ----------------------------------------------------------------------------

module positional_list_insert_delete_test;
  import pli_pkg::*;

  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
  localparam int RANDOM_REQUESTS = 1150;

  logic clk;
  logic rst_n;
  int   error_count;
  int   outstanding;
  int   fill_level;
  int   requests_sent;
  bit   no_idle;

  pli_req_if req ();
  pli_rsp_if rsp ();

  positional_list_insert_delete uut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (req),
    .out_rsp (rsp)
  );

  pli_list_checker list_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .req         (req),
    .rsp         (rsp),
    .error_count (error_count),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("FAIL");
    $finish;
  end

  function automatic logic [ELEM_WIDTH-1:0] rand_word();
    int r;
    r = $urandom_range(0, 15);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return $urandom;
  endfunction

  function automatic int pick_position(input int upper);
    if (upper < 1) return 1;
    return $urandom_range(1, upper);
  endfunction

  task automatic send_request(input logic [MODE_W-1:0] op, input int pos,
                              input logic [ELEM_WIDTH-1:0] word);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 10);
    if (gap != 0) begin
      req.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req.valid      <= 1'b1;
    req.mode       <= op;
    req.position   <= pos[POS_W-1:0];
    req.element_in <= word;
    do @(posedge clk); while (!req.ready);
    requests_sent++;
    // track the length only to steer the stimulus
    if (op == MODE_INS && pos >= 1 && pos <= fill_level + 1 && fill_level < CAPACITY)
      fill_level++;
    else if (op == MODE_DEL && pos >= 1 && pos <= fill_level)
      fill_level--;
  endtask

  task automatic wait_all_responses();
    req.valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  task automatic send_noise();
    send_request(MODE_W'($urandom_range(0, 3)), $urandom_range(0, 255), $urandom);
  endtask

  task automatic fill_round();
    int r;
    while (fill_level < CAPACITY) begin
      r = $urandom_range(0, 9);
      if (r < 7)      send_request(MODE_INS, pick_position(fill_level + 1), rand_word());
      else if (r < 9) send_request(MODE_GET, pick_position(fill_level), rand_word());
      else            send_noise();
    end
    // list is full: positions 1 to CAPACITY + 1 report full, positions beyond are bad
    send_request(MODE_INS, 1, rand_word());
    send_request(MODE_INS, CAPACITY + 1, rand_word());
    send_request(MODE_INS, pick_position(CAPACITY), rand_word());
    send_request(MODE_INS, CAPACITY + 2, rand_word());
    send_request(MODE_GET, CAPACITY, rand_word());
    send_request(MODE_DEL, CAPACITY + 1, rand_word());
  endtask

  task automatic drain_round();
    int r;
    while (fill_level > 0) begin
      r = $urandom_range(0, 9);
      if (r < 7)      send_request(MODE_DEL, pick_position(fill_level), rand_word());
      else if (r < 9) send_request(MODE_GET, pick_position(fill_level), rand_word());
      else            send_noise();
    end
    send_request(MODE_DEL, 1, rand_word());
    send_request(MODE_GET, 1, rand_word());
  endtask

  task automatic mixed_round();
    int r;
    repeat (60) begin
      r = $urandom_range(0, 19);
      if (r < 7)       send_request(MODE_INS, pick_position(fill_level + 1), rand_word());
      else if (r < 14) send_request(MODE_DEL, pick_position(fill_level), rand_word());
      else if (r < 18) send_request(MODE_GET, pick_position(fill_level), rand_word());
      else             send_noise();
    end
  endtask

  initial begin
    int kind;
    rst_n          = 1'b0;
    req.valid      = 1'b0;
    req.mode       = MODE_GET;
    req.position   = '0;
    req.element_in = '0;
    fill_level     = 0;
    requests_sent  = 0;
    no_idle        = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty list, bad positions, inserts at front, end and middle
    send_request(MODE_GET, 1, '0);
    send_request(MODE_DEL, 1, '0);
    send_request(MODE_INS, 0, '1);
    send_request(MODE_INS, 2, '1);
    send_request(MODE_INS, 1, '1);
    send_request(MODE_INS, 1, '0);
    send_request(MODE_INS, 3, 32'ha5a5_a5a5);
    send_request(MODE_INS, 2, 32'h5a5a_5a5a);
    send_request(MODE_GET, 0, '0);
    send_request(MODE_GET, 4, '0);
    send_request(MODE_GET, 5, '0);
    send_request(MODE_GET, 1, '0);
    send_request(MODE_UNUSED, 1, '1);
    send_request(MODE_UNUSED, 255, '1);
    send_request(MODE_GET, 255, '0);
    send_request(MODE_INS, 255, '1);
    send_request(MODE_DEL, 129, '0);
    send_request(MODE_DEL, 2, '0);
    send_request(MODE_DEL, 3, '0);
    send_request(MODE_DEL, 1, '0);
    send_request(MODE_GET, 1, '0);
    send_request(MODE_DEL, 1, '0);
    send_request(MODE_DEL, 1, '0);
    wait_all_responses();

    requests_sent = 0;
    kind = 0;
    while (requests_sent < RANDOM_REQUESTS) begin
      no_idle = ($urandom_range(0, 3) == 0);
      case (kind)
        0:       fill_round();
        1:       drain_round();
        default: mixed_round();
      endcase
      if ($urandom_range(0, 2) == 0) wait_all_responses();
      kind = $urandom_range(0, 3);
    end

    req.valid <= 1'b0;
    while (outstanding != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (error_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // response side stalls per request, except in stretches with no idling
  initial begin
    int gap;
    rsp.ready = 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      gap = no_idle ? 0 : $urandom_range(0, 10);
      if (gap != 0) begin
        rsp.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      rsp.ready <= 1'b1;
      do @(posedge clk); while (!rsp.valid);
    end
  end

endmodule

// File: filelist.f
sv/pli_pkg.sv
sv/pli_if.sv
sv/pli_ram.sv
sv/positional_list_insert_delete.sv
bench/pli_list_checker.sv
bench/positional_list_insert_delete_test.sv
